// File: src/t26_component_count_defines.svh
// Assertion macros shared by the t26 component count sources.
// Each macro samples on the rising edge of clk in the including module.
`ifndef T26_COMPONENT_COUNT_DEFINES_SVH
`define T26_COMPONENT_COUNT_DEFINES_SVH

`ifndef SYNTHESIS
// check a property outside reset
`define T26CC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property at every edge, reset included
`define T26CC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define T26CC_ASSERT(lbl, prop, msg)
`define T26CC_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// File: src/t26cc_pkg.sv
`default_nettype none
package t26cc_pkg;

  localparam int unsigned NumCubes = 8;
  localparam int unsigned NbW      = 27;
  localparam int unsigned CntW     = $clog2(NumCubes + 1);
  // squaring stages: 2**NumClose covers the longest path between cubes
  localparam int unsigned NumClose = 3;

  // reach[i][j]: corner cube j is linked to corner cube i
  typedef logic [NumCubes-1:0][NumCubes-1:0] reach_t;

  typedef struct packed {
    reach_t              reach;
    logic [NumCubes-1:0] corner;
  } pipe_data_t;

  // face points and the four corner cubes around each
  localparam logic [4:0] FacePt [6] = '{5'd4, 5'd10, 5'd12, 5'd14, 5'd16, 5'd22};
  localparam logic [2:0] FaceCube [6][4] = '{
    '{3'd0, 3'd1, 3'd2, 3'd3}, '{3'd0, 3'd1, 3'd4, 3'd5}, '{3'd0, 3'd2, 3'd4, 3'd6},
    '{3'd1, 3'd3, 3'd5, 3'd7}, '{3'd2, 3'd3, 3'd6, 3'd7}, '{3'd4, 3'd5, 3'd6, 3'd7}
  };

  // edge points and the two corner cubes beside each
  localparam logic [4:0] EdgePt [12] = '{
    5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd19, 5'd15, 5'd21, 5'd17, 5'd23, 5'd25
  };
  localparam logic [2:0] EdgeCube [12][2] = '{
    '{3'd0, 3'd1}, '{3'd0, 3'd2}, '{3'd1, 3'd3}, '{3'd2, 3'd3}, '{3'd0, 3'd4},
    '{3'd1, 3'd5}, '{3'd4, 3'd5}, '{3'd2, 3'd6}, '{3'd4, 3'd6}, '{3'd3, 3'd7},
    '{3'd5, 3'd7}, '{3'd6, 3'd7}
  };

  // outer corner point of each cube
  localparam logic [4:0] CornerPt [NumCubes] = '{
    5'd0, 5'd2, 5'd6, 5'd8, 5'd18, 5'd20, 5'd24, 5'd26
  };

  // one-step links between cubes, each cube linked to itself
  function automatic reach_t build_adj(logic [NbW-1:0] nb);
    reach_t a;
    a = '0;
    for (int i = 0; i < NumCubes; i++) begin
      a[i][i] = 1'b1;
    end
    for (int f = 0; f < 6; f++) begin
      if (nb[FacePt[f]]) begin
        for (int p = 0; p < 4; p++) begin
          for (int q = 0; q < 4; q++) begin
            a[FaceCube[f][p]][FaceCube[f][q]] = 1'b1;
          end
        end
      end
    end
    for (int e = 0; e < 12; e++) begin
      if (nb[EdgePt[e]]) begin
        a[EdgeCube[e][0]][EdgeCube[e][1]] = 1'b1;
        a[EdgeCube[e][1]][EdgeCube[e][0]] = 1'b1;
      end
    end
    return a;
  endfunction

  function automatic logic [NumCubes-1:0] corner_bits(logic [NbW-1:0] nb);
    logic [NumCubes-1:0] c;
    for (int i = 0; i < NumCubes; i++) begin
      c[i] = nb[CornerPt[i]];
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: src/t26cc_adj_stage.sv
`default_nettype none
module t26cc_adj_stage import t26cc_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           up_valid,
  output logic                up_stall,
  input  wire logic [NbW-1:0] up_nb,
  output logic                dn_valid,
  input  wire logic           dn_stall,
  output pipe_data_t          dn_data
);

  logic       valid_r;
  pipe_data_t data_r;
  pipe_data_t data_nxt;

  // hold while a beat sits here and downstream stalls
  assign up_stall = valid_r && dn_stall;

  // build direct cube links and pick up corner points
  always_comb begin
    data_nxt.reach  = build_adj(up_nb);
    data_nxt.corner = corner_bits(up_nb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
`default_nettype wire

// File: src/t26cc_close_stage.sv
`default_nettype none
module t26cc_close_stage import t26cc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       up_valid,
  output logic            up_stall,
  input  wire pipe_data_t up_data,
  output logic            dn_valid,
  input  wire logic       dn_stall,
  output pipe_data_t      dn_data
);

  logic       valid_r;
  pipe_data_t data_r;
  pipe_data_t data_nxt;

  assign up_stall = valid_r && dn_stall;

  // square the reach matrix: doubles the path length covered
  always_comb begin
    data_nxt.corner = up_data.corner;
    for (int i = 0; i < NumCubes; i++) begin
      for (int j = 0; j < NumCubes; j++) begin
        data_nxt.reach[i][j] = |(up_data.reach[i] & up_data.reach[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
`default_nettype wire

// File: src/t26cc_count_stage.sv
`default_nettype none
module t26cc_count_stage import t26cc_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_stall,
  input  wire pipe_data_t      up_data,
  output logic                 dn_valid,
  input  wire logic            dn_stall,
  output logic [CntW-1:0]      dn_count
);

  logic            valid_r;
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;

  assign up_stall = valid_r && dn_stall;

  // count each class once, at its smallest cube; a lone cube needs its corner
  always_comb begin
    logic is_min;
    logic linked;
    count_nxt = '0;
    for (int i = 0; i < NumCubes; i++) begin
      is_min = 1'b1;
      linked = 1'b0;
      for (int j = 0; j < NumCubes; j++) begin
        if (j < i && up_data.reach[i][j]) begin
          is_min = 1'b0;
        end
        if (j != i && up_data.reach[i][j]) begin
          linked = 1'b1;
        end
      end
      if (is_min && (linked || up_data.corner[i])) begin
        count_nxt = count_nxt + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      count_r <= count_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_count = count_r;

endmodule
`default_nettype wire

// File: src/t26_component_count.sv
// T26 component count: number of 26-connected object components in a
// 3x3x3 voxel neighborhood with the centre point removed.
// Input channel: in_valid / in_stall carry one in_voxel_neighborhood beat
// (bit k is point k = 9*plane + 3*row + column; bit 13 is ignored).
// Output channel: out_valid / out_stall carry one out_component_count beat
// (0..8) for every input beat, in input order.
// Pipeline: five register stages (direct cube links, three squarings of the
// 8x8 cube reach matrix, count), in that order. One beat enters per cycle
// while the output flows.
// Stall: each stage holds only when it is full and the next one holds, so
// bubbles collapse; with out_stall high the pipeline fills up to five beats
// and then raises in_stall. Nothing is dropped or repeated.
// Reset: synchronous, active low rst_n empties every stage; there is no
// other state and no configuration.
`default_nettype none
`include "t26_component_count_defines.svh"
module t26_component_count import t26cc_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [NbW-1:0]  in_voxel_neighborhood,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [CntW-1:0]      out_component_count
);

  logic       vld  [NumClose+1];
  logic       stl  [NumClose+1];
  pipe_data_t data [NumClose+1];

  // stage 0: direct links
  t26cc_adj_stage u_adj (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_nb    (in_voxel_neighborhood),
    .dn_valid (vld[0]),
    .dn_stall (stl[0]),
    .dn_data  (data[0])
  );

  // stages 1..3: transitive closure by repeated squaring
  for (genvar g = 0; g < NumClose; g++) begin : g_close
    t26cc_close_stage u_close (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[g]),
      .up_stall (stl[g]),
      .up_data  (data[g]),
      .dn_valid (vld[g+1]),
      .dn_stall (stl[g+1]),
      .dn_data  (data[g+1])
    );
  end

  // stage 4: count roots into the output register
  t26cc_count_stage u_count (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (vld[NumClose]),
    .up_stall (stl[NumClose]),
    .up_data  (data[NumClose]),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_count (out_component_count)
  );

  // stalls only start at the output side
  `T26CC_ASSERT(a_stall_from_out, in_stall |-> out_stall, "input stalled without output stall")
  `T26CC_ASSERT(a_flow_when_free, !out_stall |-> !in_stall, "input stalled while output flows")
  `T26CC_ASSERT(a_count_range, out_valid |-> (out_component_count <= CntW'(NumCubes)),
                "component count above eight")
  `T26CC_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "output valid right after reset")

endmodule
`default_nettype wire
